[rtl/assert_macros.svh]
// Assertion macros for the checker file gwb_chk.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

[rtl/gwb_pkg.sv]
// Types, constants and helper functions for the grey-world white balance block.
package gwb_pkg;

	localparam int MEAN_W = 20;
	localparam int GAIN_W = 16;
	localparam int PROD_W = MEAN_W + GAIN_W;
	localparam int SUM_W  = GAIN_W + 2;

	localparam int APB_AW = 4;
	localparam int APB_DW = 32;

	typedef logic [MEAN_W-1:0] mean_t;
	typedef logic [GAIN_W-1:0] gain_t;
	typedef logic [PROD_W-1:0] prod_t;
	typedef logic [SUM_W-1:0]  sum_t;
	typedef logic [1:0]        reg_idx_t;

	localparam reg_idx_t REG_UNITY = 2'd0;
	localparam reg_idx_t REG_MIN   = 2'd1;
	localparam reg_idx_t REG_MAX   = 2'd2;

	localparam gain_t UNITY_RST    = 16'd256;
	localparam gain_t GAIN_MIN_RST = 16'd64;
	localparam gain_t GAIN_MAX_RST = 16'd1023;
	localparam gain_t GAIN_RST     = 16'd256;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_START,
		ST_DIV,
		ST_CLAMP,
		ST_MOVE,
		ST_OUT
	} state_t;

	typedef enum logic {
		CH_RED,
		CH_BLUE
	} chan_t;

	// Lower bound first, then upper bound.
	function automatic gain_t clamp_gain(prod_t v, gain_t lo, gain_t hi);
		prod_t t;
		t = (v < prod_t'(lo)) ? prod_t'(lo) : v;
		return (t > prod_t'(hi)) ? hi : t[GAIN_W-1:0];
	endfunction

endpackage

[rtl/gwb_if.sv]
// Handshake channel interfaces for the statistics input and the gain output.
interface gwb_in_if;
	logic           valid;
	logic           ready;
	gwb_pkg::mean_t blue_mean;
	gwb_pkg::mean_t green_mean;
	gwb_pkg::mean_t red_mean;

	modport source (output valid, output blue_mean, output green_mean, output red_mean,
		input ready);
	modport sink (input valid, input blue_mean, input green_mean, input red_mean,
		output ready);
endinterface

interface gwb_out_if;
	logic           valid;
	logic           ready;
	gwb_pkg::gain_t red_gain_out;
	gwb_pkg::gain_t green_gain_out;
	gwb_pkg::gain_t blue_gain_out;
	logic           gain_changed;

	modport source (output valid, output red_gain_out, output green_gain_out,
		output blue_gain_out, output gain_changed, input ready);
	modport sink (input valid, input red_gain_out, input green_gain_out,
		input blue_gain_out, input gain_changed, output ready);
endinterface

[rtl/grey_world_white_balance_step.sv]
// Grey-world white balance step: sequencer, gain state and configuration registers.
//
// stat_in carries one frame's blue, green and red means; gain_out returns one item
// per input item with the red, green and blue gains and a changed flag.
// Both channels use valid/ready; an item moves when both are high at a clock edge.
// Configuration (unity_gain, gain_min, gain_max) sits on an APB port at byte
// addresses 0, 4 and 8; write only while the block is idle.
// Each item makes two passes through the one shared radix-2 divider (red, then
// blue), each with setup, clamp and move states. When any mean is zero the
// divider is skipped and the gains hold.
// stat_in.ready is high only while the sequencer is idle, so no new item is
// taken while the last one is still being computed.
// A finished result waits in the output register while the next item is taken
// and computed; if the receiver still stalls when that next result is ready,
// the sequencer holds until the output register frees.
// Reset (arst_n low) clears the sequencer and the output valid, sets both gains
// to 256 and loads the default register values.
module grey_world_white_balance_step (
	input  logic                       clk,
	input  logic                       arst_n,
	gwb_in_if.sink                     stat_in,
	gwb_out_if.source                  gain_out,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [gwb_pkg::APB_AW-1:0] paddr,
	input  logic [gwb_pkg::APB_DW-1:0] pwdata,
	output logic [gwb_pkg::APB_DW-1:0] prdata,
	output logic                       pready
);

	gwb_pkg::state_t   state_q;
	gwb_pkg::state_t   state_d;
	gwb_pkg::chan_t    sel_q;

	gwb_pkg::gain_t    unity_q;
	gwb_pkg::gain_t    gmin_q;
	gwb_pkg::gain_t    gmax_q;
	gwb_pkg::gain_t    red_q;
	gwb_pkg::gain_t    blue_q;

	gwb_pkg::mean_t    b_q;
	gwb_pkg::mean_t    g_q;
	gwb_pkg::mean_t    r_q;
	gwb_pkg::prod_t    prod_q;
	logic              zero_q;
	gwb_pkg::gain_t    tgt_q;
	gwb_pkg::gain_t    new_r_q;
	gwb_pkg::gain_t    new_b_q;

	logic              out_valid_q;
	gwb_pkg::gain_t    out_red_q;
	gwb_pkg::gain_t    out_green_q;
	gwb_pkg::gain_t    out_blue_q;
	logic              out_chg_q;

	logic              accept;
	logic              any_zero;
	logic              out_free;
	logic              load;
	logic              div_start;
	logic              div_done;
	gwb_pkg::mean_t    div_dvs;
	gwb_pkg::prod_t    div_quo;
	gwb_pkg::gain_t    old_gain;
	gwb_pkg::sum_t     move_sum;
	gwb_pkg::gain_t    move_n;
	gwb_pkg::gain_t    move_gain;
	logic              cfg_wr;
	gwb_pkg::reg_idx_t cfg_idx;

	assign accept   = stat_in.valid && stat_in.ready;
	assign any_zero = (b_q == '0) || (g_q == '0) || (r_q == '0);
	assign out_free = !out_valid_q || gain_out.ready;
	assign div_dvs  = (sel_q == gwb_pkg::CH_RED) ? r_q : b_q;

	gwb_div #(
		.DVD_W(gwb_pkg::PROD_W),
		.DVS_W(gwb_pkg::MEAN_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (prod_q),
		.divisor  (div_dvs),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			gwb_pkg::ST_IDLE: begin
				if (stat_in.valid) state_d = gwb_pkg::ST_MUL;
			end
			gwb_pkg::ST_MUL: begin
				state_d = any_zero ? gwb_pkg::ST_OUT : gwb_pkg::ST_START;
			end
			gwb_pkg::ST_START: begin
				state_d = gwb_pkg::ST_DIV;
			end
			gwb_pkg::ST_DIV: begin
				if (div_done) state_d = gwb_pkg::ST_CLAMP;
			end
			gwb_pkg::ST_CLAMP: begin
				state_d = gwb_pkg::ST_MOVE;
			end
			gwb_pkg::ST_MOVE: begin
				state_d = (sel_q == gwb_pkg::CH_RED) ? gwb_pkg::ST_START : gwb_pkg::ST_OUT;
			end
			gwb_pkg::ST_OUT: begin
				if (out_free) state_d = gwb_pkg::ST_IDLE;
			end
			default: begin
				state_d = gwb_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		stat_in.ready = 1'b0;
		div_start     = 1'b0;
		load          = 1'b0;
		case (state_q)
			gwb_pkg::ST_IDLE:  stat_in.ready = 1'b1;
			gwb_pkg::ST_START: div_start     = 1'b1;
			gwb_pkg::ST_OUT:   load          = out_free;
			default: begin
				stat_in.ready = 1'b0;
			end
		endcase
	end

	always_comb begin
		old_gain  = (sel_q == gwb_pkg::CH_RED) ? red_q : blue_q;
		move_sum  = (gwb_pkg::sum_t'(old_gain) << 1) + gwb_pkg::sum_t'(old_gain)
			+ gwb_pkg::sum_t'(tgt_q);
		move_n    = move_sum[gwb_pkg::SUM_W-1:2];
		move_gain = gwb_pkg::clamp_gain(gwb_pkg::prod_t'(move_n), gmin_q, gmax_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= gwb_pkg::ST_IDLE;
			sel_q       <= gwb_pkg::CH_RED;
			red_q       <= gwb_pkg::GAIN_RST;
			blue_q      <= gwb_pkg::GAIN_RST;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == gwb_pkg::ST_MUL) begin
				sel_q <= gwb_pkg::CH_RED;
			end else if (state_q == gwb_pkg::ST_MOVE) begin
				sel_q <= gwb_pkg::CH_BLUE;
			end
			if (load) begin
				out_valid_q <= 1'b1;
				if (!zero_q) begin
					red_q  <= new_r_q;
					blue_q <= new_b_q;
				end
			end else if (gain_out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			b_q <= stat_in.blue_mean;
			g_q <= stat_in.green_mean;
			r_q <= stat_in.red_mean;
		end
		if (state_q == gwb_pkg::ST_MUL) begin
			prod_q <= gwb_pkg::prod_t'(unity_q) * gwb_pkg::prod_t'(g_q);
			zero_q <= any_zero;
		end
		if (state_q == gwb_pkg::ST_CLAMP) begin
			tgt_q <= gwb_pkg::clamp_gain(div_quo, gmin_q, gmax_q);
		end
		if (state_q == gwb_pkg::ST_MOVE) begin
			if (sel_q == gwb_pkg::CH_RED) begin
				new_r_q <= move_gain;
			end else begin
				new_b_q <= move_gain;
			end
		end
		if (load) begin
			out_green_q <= unity_q;
			if (zero_q) begin
				out_red_q  <= red_q;
				out_blue_q <= blue_q;
				out_chg_q  <= 1'b0;
			end else begin
				out_red_q  <= new_r_q;
				out_blue_q <= new_b_q;
				out_chg_q  <= (new_r_q != red_q) || (new_b_q != blue_q);
			end
		end
	end

	assign gain_out.valid          = out_valid_q;
	assign gain_out.red_gain_out   = out_red_q;
	assign gain_out.green_gain_out = out_green_q;
	assign gain_out.blue_gain_out  = out_blue_q;
	assign gain_out.gain_changed   = out_chg_q;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_idx = paddr[3:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unity_q <= gwb_pkg::UNITY_RST;
			gmin_q  <= gwb_pkg::GAIN_MIN_RST;
			gmax_q  <= gwb_pkg::GAIN_MAX_RST;
		end else if (cfg_wr) begin
			case (cfg_idx)
				gwb_pkg::REG_UNITY: unity_q <= pwdata[gwb_pkg::GAIN_W-1:0];
				gwb_pkg::REG_MIN:   gmin_q  <= pwdata[gwb_pkg::GAIN_W-1:0];
				gwb_pkg::REG_MAX:   gmax_q  <= pwdata[gwb_pkg::GAIN_W-1:0];
				default: begin
					unity_q <= unity_q;
				end
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			gwb_pkg::REG_UNITY: prdata = gwb_pkg::APB_DW'(unity_q);
			gwb_pkg::REG_MIN:   prdata = gwb_pkg::APB_DW'(gmin_q);
			gwb_pkg::REG_MAX:   prdata = gwb_pkg::APB_DW'(gmax_q);
			default:            prdata = '0;
		endcase
	end

endmodule

[rtl/gwb_div.sv]
// Restoring radix-2 divider, one quotient bit per cycle.
module gwb_div #(
	parameter int DVD_W = gwb_pkg::PROD_W,
	parameter int DVS_W = gwb_pkg::MEAN_W
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic             done,
	output logic [DVD_W-1:0] quotient
);

	localparam int CNT_W = (DVD_W > 1) ? $clog2(DVD_W) : 1;
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DVD_W - 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVS_W-1:0] dvs_q;
	logic [DVD_W-1:0] qd_q;

	logic [DVS_W:0]   rem_sh;
	logic [DVS_W:0]   diff;
	logic             ge;
	logic [DVS_W-1:0] rem_d;
	logic [DVD_W-1:0] qd_d;

	always_comb begin
		rem_sh = {rem_q, qd_q[DVD_W-1]};
		diff   = rem_sh - {1'b0, dvs_q};
		ge     = (rem_sh >= {1'b0, dvs_q});
		rem_d  = ge ? diff[DVS_W-1:0] : rem_sh[DVS_W-1:0];
		qd_d   = {qd_q[DVD_W-2:0], ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvs_q <= divisor;
			qd_q  <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= rem_d;
			qd_q  <= qd_d;
		end
	end

	assign done     = done_q;
	assign quotient = qd_q;

endmodule

[rtl/gwb_chk.sv]
// Port-level checker for the white balance step, bound to the top level.
`include "assert_macros.svh"

module gwb_chk (
	input logic           clk,
	input logic           arst_n,
	input logic           in_valid,
	input logic           in_ready,
	input logic           out_valid,
	input logic           out_ready,
	input gwb_pkg::gain_t red_gain_out,
	input gwb_pkg::gain_t green_gain_out,
	input gwb_pkg::gain_t blue_gain_out,
	input logic           gain_changed
);

	logic                        in_acc;
	logic                        out_stall;
	logic [3*gwb_pkg::GAIN_W:0]  out_word;

	assign in_acc    = in_valid && in_ready;
	assign out_stall = out_valid && !out_ready;
	assign out_word  = {red_gain_out, green_gain_out, blue_gain_out, gain_changed};

	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_stall, out_valid)
	`ASSERT_NEXT(a_out_stable, clk, arst_n, out_stall, $stable(out_word))
	`ASSERT_NEXT(a_busy_after_acc, clk, arst_n, in_acc, !in_ready ##1 !in_ready)
	`ASSERT_NEXT(a_no_instant_result, clk, arst_n, in_acc && !out_valid, !out_valid)

endmodule

bind grey_world_white_balance_step gwb_chk u_gwb_chk (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (stat_in.valid),
	.in_ready       (stat_in.ready),
	.out_valid      (gain_out.valid),
	.out_ready      (gain_out.ready),
	.red_gain_out   (gain_out.red_gain_out),
	.green_gain_out (gain_out.green_gain_out),
	.blue_gain_out  (gain_out.blue_gain_out),
	.gain_changed   (gain_out.gain_changed)
);

[verif/grey_world_white_balance_step_test.sv]
// Self-checking testbench for the grey-world white balance step block.
`timescale 1ns / 100ps

module grey_world_white_balance_step_test;
	import gwb_pkg::*;

	localparam int CYCLE_LIMIT = 600000;
	localparam int HOLD_CYCLES = 600;
	localparam int PHASES      = 7;
	localparam int PHASE_ITEMS = 148;
	localparam mean_t MEAN_MAX = 20'hFFFFF;

	typedef struct packed {
		gain_t red;
		gain_t green;
		gain_t blue;
		logic  changed;
	} gains_t;

	typedef enum logic {
		ROW_ITEM,
		ROW_WRITE
	} row_kind_t;

	typedef struct packed {
		row_kind_t kind;
		reg_idx_t  idx;
		gain_t     value;
		mean_t     b;
		mean_t     g;
		mean_t     r;
		logic      typed;
		gains_t    want;
	} row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic pready;

	gwb_in_if  stat_in ();
	gwb_out_if gain_out ();

	grey_world_white_balance_step dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.stat_in  (stat_in),
		.gain_out (gain_out),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always #2 clk = ~clk;

	gain_t cfg_unity;
	gain_t cfg_min;
	gain_t cfg_max;
	gain_t cur_red;
	gain_t cur_blue;

	gains_t gains_due[$];
	row_t   plan[$];
	int     mismatches = 0;
	int     cycles = 0;
	bit     idle_on = 1'b1;
	bit     hold_rx = 1'b0;

	task automatic note_error(string what, int unsigned got, int unsigned want);
		$display("mismatch %s: got %0d, want %0d (t=%0t)", what, got, want, $time);
		mismatches++;
	endtask

	function automatic gain_t bound_gain(logic [63:0] v);
		logic [63:0] t;
		t = v;
		if (t < 64'(cfg_min))
			t = 64'(cfg_min);
		if (t > 64'(cfg_max))
			t = 64'(cfg_max);
		return t[GAIN_W-1:0];
	endfunction

	function automatic gain_t ease_gain(gain_t old, logic [63:0] target);
		logic [63:0] n;
		n = (64'(old) * 64'd3 + 64'(bound_gain(target))) / 64'd4;
		return bound_gain(n);
	endfunction

	function automatic gains_t step_gains(mean_t b, mean_t g, mean_t r);
		gains_t o;
		logic [63:0] prod;
		gain_t nr;
		gain_t nb;
		o.changed = 1'b0;
		if (b != 0 && g != 0 && r != 0) begin
			prod = 64'(cfg_unity) * 64'(g);
			nr = ease_gain(cur_red, prod / 64'(r));
			nb = ease_gain(cur_blue, prod / 64'(b));
			o.changed = (nr != cur_red) || (nb != cur_blue);
			cur_red = nr;
			cur_blue = nb;
		end
		o.red = cur_red;
		o.green = cfg_unity;
		o.blue = cur_blue;
		return o;
	endfunction

	function automatic row_t stat_row(mean_t b, mean_t g, mean_t r);
		row_t x;
		x = '0;
		x.kind = ROW_ITEM;
		x.b = b;
		x.g = g;
		x.r = r;
		return x;
	endfunction

	function automatic row_t known_row(mean_t b, mean_t g, mean_t r, gain_t red, gain_t green,
			gain_t blue, logic chg);
		row_t x;
		x = stat_row(b, g, r);
		x.typed = 1'b1;
		x.want.red = red;
		x.want.green = green;
		x.want.blue = blue;
		x.want.changed = chg;
		return x;
	endfunction

	function automatic row_t reg_row(reg_idx_t idx, gain_t value);
		row_t x;
		x = '0;
		x.kind = ROW_WRITE;
		x.idx = idx;
		x.value = value;
		return x;
	endfunction

	function automatic mean_t rand_mean();
		mean_t m;
		m = mean_t'($urandom) >> $urandom_range(19, 0);
		return (m == 0) ? mean_t'(1) : m;
	endfunction

	function automatic mean_t near_mean(mean_t base);
		logic [63:0] v;
		v = (64'(base) * 64'($urandom_range(40, 4))) / 64'd16;
		if (v == 0)
			v = 64'd1;
		if (v > 64'(MEAN_MAX))
			v = 64'(MEAN_MAX);
		return v[MEAN_W-1:0];
	endfunction

	task automatic write_reg(reg_idx_t idx, gain_t value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= APB_DW'(value);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_UNITY: cfg_unity = value;
			REG_MIN:   cfg_min = value;
			REG_MAX:   cfg_max = value;
			default: ;
		endcase
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata[GAIN_W-1:0] !== value)
			note_error("register readback", prdata[GAIN_W-1:0], value);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_item(mean_t b, mean_t g, mean_t r, logic typed, gains_t want);
		int gap;
		gains_t predicted;
		gap = idle_on ? $urandom_range(12, 0) : 0;
		if (gap > 0) begin
			stat_in.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		stat_in.valid <= 1'b1;
		stat_in.blue_mean <= b;
		stat_in.green_mean <= g;
		stat_in.red_mean <= r;
		do @(posedge clk); while (!stat_in.ready);
		predicted = step_gains(b, g, r);
		gains_due.push_back(typed ? want : predicted);
	endtask

	// drop valid and wait until every result is back
	task automatic settle();
		stat_in.valid <= 1'b0;
		@(posedge clk);
		while (gains_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	always @(posedge clk) begin
		gains_t want;
		if (arst_n === 1'b1 && gain_out.valid === 1'b1 && gain_out.ready === 1'b1) begin
			if (gains_due.size() == 0) begin
				note_error("result with nothing due", gain_out.red_gain_out, 0);
			end else begin
				want = gains_due.pop_front();
				if (gain_out.red_gain_out !== want.red)
					note_error("red_gain_out", gain_out.red_gain_out, want.red);
				if (gain_out.green_gain_out !== want.green)
					note_error("green_gain_out", gain_out.green_gain_out, want.green);
				if (gain_out.blue_gain_out !== want.blue)
					note_error("blue_gain_out", gain_out.blue_gain_out, want.blue);
				if (gain_out.gain_changed !== want.changed)
					note_error("gain_changed", gain_out.gain_changed, want.changed);
			end
		end
	end

	initial begin
		int stall;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_rx) begin
				stall = HOLD_CYCLES;
				hold_rx = 1'b0;
			end else begin
				stall = idle_on ? $urandom_range(12, 0) : 0;
			end
			if (stall > 0) begin
				gain_out.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			gain_out.ready <= 1'b1;
			do @(posedge clk); while (gain_out.valid !== 1'b1);
		end
	end

	initial begin
		mean_t b;
		mean_t g;
		mean_t r;
		int sel;
		gain_t u;
		gain_t lo;
		gain_t hi;

		arst_n <= 1'b0;
		stat_in.valid <= 1'b0;
		stat_in.blue_mean <= '0;
		stat_in.green_mean <= '0;
		stat_in.red_mean <= '0;
		gain_out.ready <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		cfg_unity = UNITY_RST;
		cfg_min = GAIN_MIN_RST;
		cfg_max = GAIN_MAX_RST;
		cur_red = GAIN_RST;
		cur_blue = GAIN_RST;

		plan.push_back(known_row(0, 0, 0, 256, 256, 256, 0));
		plan.push_back(known_row(0, MEAN_MAX, MEAN_MAX, 256, 256, 256, 0));
		plan.push_back(known_row(MEAN_MAX, 0, MEAN_MAX, 256, 256, 256, 0));
		plan.push_back(known_row(MEAN_MAX, MEAN_MAX, 0, 256, 256, 256, 0));
		plan.push_back(known_row(1000, 1000, 1000, 256, 256, 256, 0));
		plan.push_back(known_row(MEAN_MAX, MEAN_MAX, MEAN_MAX, 256, 256, 256, 0));
		plan.push_back(stat_row(1, MEAN_MAX, 1));
		plan.push_back(stat_row(MEAN_MAX, 1, MEAN_MAX));
		plan.push_back(stat_row(20'hAAAAA, 20'h55555, 20'hAAAAA));
		plan.push_back(stat_row(20'h55555, 20'hAAAAA, 20'h55555));
		plan.push_back(reg_row(REG_UNITY, 16'hFFFF));
		plan.push_back(reg_row(REG_MIN, 16'h0000));
		plan.push_back(reg_row(REG_MAX, 16'hFFFF));
		plan.push_back(stat_row(1, MEAN_MAX, 1));
		plan.push_back(stat_row(0, 5, 5));
		plan.push_back(reg_row(REG_MIN, 16'hFFFF));
		plan.push_back(reg_row(REG_MAX, 16'h0000));
		plan.push_back(stat_row(300, 700, 900));
		plan.push_back(known_row(300, 700, 900, 0, 16'hFFFF, 0, 0));
		plan.push_back(reg_row(REG_UNITY, 16'h0000));
		plan.push_back(reg_row(REG_MIN, 16'd100));
		plan.push_back(reg_row(REG_MAX, 16'd2000));
		plan.push_back(known_row(50, 60, 70, 100, 0, 100, 1));
		plan.push_back(known_row(MEAN_MAX, MEAN_MAX, MEAN_MAX, 100, 0, 100, 0));
		plan.push_back(reg_row(REG_UNITY, 16'd1));
		plan.push_back(reg_row(REG_MIN, 16'd0));
		plan.push_back(reg_row(REG_MAX, 16'hFFFF));
		plan.push_back(stat_row(1, MEAN_MAX, 2));
		plan.push_back(stat_row(3, 1, MEAN_MAX));

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_WRITE) begin
				settle();
				write_reg(plan[i].idx, plan[i].value);
			end else begin
				send_item(plan[i].b, plan[i].g, plan[i].r, plan[i].typed, plan[i].want);
			end
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			settle();
			case (ph)
				0, 6: begin
					u = $urandom_range(512, 64);
					lo = $urandom_range(128, 0);
					hi = $urandom_range(4095, 512);
				end
				1: begin
					u = $urandom;
					lo = $urandom;
					hi = $urandom;
				end
				2: begin
					u = 16'hFFFF;
					lo = 16'h0000;
					hi = 16'hFFFF;
				end
				3: begin
					u = 16'd1;
					lo = 16'h0000;
					hi = 16'hFFFF;
				end
				4: begin
					u = UNITY_RST;
					lo = GAIN_MIN_RST;
					hi = GAIN_MAX_RST;
				end
				default: begin
					u = $urandom;
					lo = $urandom_range(65535, 32768);
					hi = $urandom_range(32767, 0);
				end
			endcase
			write_reg(REG_UNITY, u);
			write_reg(REG_MIN, lo);
			write_reg(REG_MAX, hi);
			idle_on = (ph % 3 != 2);
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				sel = $urandom_range(19, 0);
				if (sel < 14) begin
					g = rand_mean();
					r = near_mean(g);
					b = near_mean(g);
				end else if (sel < 17) begin
					b = rand_mean();
					g = rand_mean();
					r = rand_mean();
				end else if (sel == 17) begin
					b = $urandom_range(1, 0) ? MEAN_MAX : mean_t'(1);
					g = $urandom_range(1, 0) ? MEAN_MAX : mean_t'(1);
					r = $urandom_range(1, 0) ? MEAN_MAX : mean_t'(1);
				end else begin
					b = rand_mean();
					g = rand_mean();
					r = rand_mean();
					case ($urandom_range(2, 0))
						0: b = '0;
						1: g = '0;
						default: r = '0;
					endcase
				end
				if (ph == 1 && k == 40)
					hold_rx = 1'b1;
				send_item(b, g, r, 1'b0, '0);
			end
		end

		settle();
		repeat (90) @(posedge clk);
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

[files.f]
+incdir+rtl
rtl/gwb_pkg.sv
rtl/gwb_if.sv
rtl/gwb_div.sv
rtl/grey_world_white_balance_step.sv
rtl/gwb_chk.sv
verif/grey_world_white_balance_step_test.sv
